[design/trm_pkg.sv]
// Package for the texture coordinate range mapper: widths, mode bits, register map.
`default_nettype none
package trm_pkg;
  localparam int WordBits = 32;
  localparam int FractionBits = 16;
  localparam int ModeBits = 5;
  localparam int AddrBits = 5;

  localparam int ModeAbs = 0;
  localparam int ModeClamp = 1;
  localparam int ModeRepeat = 2;
  localparam int ModeCenter = 3;
  localparam int ModeScale = 4;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegClampLow = 3'd1;
  localparam logic [2:0] RegClampHigh = 3'd2;
  localparam logic [2:0] RegRepeatLow = 3'd3;
  localparam logic [2:0] RegRepeatHigh = 3'd4;
  localparam logic [2:0] RegRangeLow = 3'd5;
  localparam logic [2:0] RegRangeHigh = 3'd6;

  // Operation chosen for the divider path.
  typedef enum logic [2:0] {
    OP_ZERO   = 3'b001,
    OP_DIVIDE = 3'b010,
    OP_PASS   = 3'b100
  } op_t;
endpackage
`default_nettype wire

[design/trm_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, sign and saturation handling.
`default_nettype none
module trm_divider #(
  parameter int NumBits = 2 * trm_pkg::WordBits + 2,
  parameter int WordBits = trm_pkg::WordBits
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic                      in_valid,
  input  wire logic [NumBits-1:0]        in_num,
  input  wire logic [WordBits:0]         in_den,
  input  wire logic                      in_neg,
  input  wire logic                      in_den_zero,
  input  wire logic signed [WordBits+1:0] in_offset,
  input  wire logic                      in_sub,
  input  wire logic                      in_bypass,
  input  wire logic signed [WordBits-1:0] in_bypass_value,
  input  wire logic                      in_sat,
  output logic                           out_valid,
  output logic signed [WordBits-1:0]     out_value,
  output logic                           out_sat
);
  import trm_pkg::*;

  localparam int S = NumBits;
  localparam int RB = WordBits + 2;
  localparam logic signed [WordBits+1:0] WMax = (WordBits+2)'((64'd1 << (WordBits - 1)) - 64'd1);
  localparam logic signed [WordBits+1:0] WMin = -WMax - (WordBits+2)'(1);

  logic               v   [S+1];
  logic [NumBits-1:0] q   [S+1];
  logic [RB-1:0]      r   [S+1];
  logic [WordBits:0]  d   [S+1];
  logic               ng  [S+1];
  logic               dz  [S+1];
  logic signed [WordBits+1:0] off [S+1];
  logic               sb  [S+1];
  logic               byp [S+1];
  logic signed [WordBits-1:0] bv [S+1];
  logic               st  [S+1];

  always_comb begin
    v[0] = in_valid; q[0] = in_num; r[0] = '0; d[0] = in_den; ng[0] = in_neg;
    dz[0] = in_den_zero; off[0] = in_offset; sb[0] = in_sub; byp[0] = in_bypass;
    bv[0] = in_bypass_value; st[0] = in_sat;
  end

  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [RB:0] shifted;
    logic [RB:0] diff;
    always_comb begin
      shifted = {r[i], q[i][NumBits-1]};
      diff = shifted - {2'b00, d[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (advance) begin
        v[i+1] <= v[i];
      end
      if (advance) begin
        if (!diff[RB]) begin
          r[i+1] <= diff[RB-1:0];
        end else begin
          r[i+1] <= shifted[RB-1:0];
        end
        q[i+1] <= {q[i][NumBits-2:0], ~diff[RB]};
        d[i+1] <= d[i]; ng[i+1] <= ng[i]; dz[i+1] <= dz[i]; off[i+1] <= off[i];
        sb[i+1] <= sb[i]; byp[i+1] <= byp[i]; bv[i+1] <= bv[i]; st[i+1] <= st[i];
      end
    end
  end

  // Final stage: sign, quotient saturation, offset add or subtract, word saturation, or the bypass value.
  logic                       big;
  logic signed [WordBits+1:0] sq;
  logic signed [WordBits+2:0] sum;
  logic                       qsat;
  always_comb begin
    big = |q[S][NumBits-1:WordBits+1];
    qsat = 1'b0;
    if (dz[S]) begin
      qsat = 1'b1;
      sq = ng[S] ? WMin : WMax;
    end else if (big || ($signed({1'b0, q[S][WordBits:0]}) >
                          (ng[S] ? -WMin : WMax))) begin
      qsat = 1'b1;
      sq = ng[S] ? WMin : WMax;
    end else begin
      sq = ng[S] ? -$signed({1'b0, q[S][WordBits:0]}) : $signed({1'b0, q[S][WordBits:0]});
    end
    if (sb[S]) begin
      sum = (WordBits+3)'(off[S]) - (WordBits+3)'(sq);
    end else begin
      sum = (WordBits+3)'(sq) + (WordBits+3)'(off[S]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v[S];
    end
    if (advance) begin
      if (byp[S]) begin
        out_value <= bv[S];
        out_sat <= st[S];
      end else if (sum > (WordBits+3)'(WMax)) begin
        out_value <= WMax[WordBits-1:0];
        out_sat <= 1'b1;
      end else if (sum < (WordBits+3)'(WMin)) begin
        out_value <= WMin[WordBits-1:0];
        out_sat <= 1'b1;
      end else begin
        out_value <= sum[WordBits-1:0];
        out_sat <= st[S] | qsat;
      end
    end
  end
endmodule
`default_nettype wire

[design/texcoord_range_mapper.sv]
// Top level of the texture coordinate range mapper: register file, front stages, divider.
//
// Maps one signed Q16.16 sample to a texture coordinate per beat. The path is a
// pipeline: absolute value, clamp, operand setup with one multiply, then a restoring
// divider of one quotient bit per stage, then sign, offset and saturation. A new beat
// enters every cycle unless the output stalls; the result is held in an output register.
// The whole pipeline advances when the output register is empty or being taken, so
// a stall holds every stage and loses nothing. Registers lie at byte address 4*index
// and must only be written while the pipeline holds no beats.
`default_nettype none
module texcoord_range_mapper #(
  parameter int WORD_BITS = trm_pkg::WordBits,
  parameter int FRACTION_BITS = trm_pkg::FractionBits
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [trm_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [WORD_BITS-1:0] s_tdata,   // sample_value
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [WORD_BITS-1:0]      m_tdata,   // mapped_value
  output logic                      m_tuser    // saturated
);
  import trm_pkg::*;

  localparam int W = WORD_BITS;
  localparam int NB = 2 * W + 2;
  localparam logic signed [W:0] WMax = (W+1)'((65'd1 << (W - 1)) - 65'd1);
  localparam logic signed [W+1:0] OneFix = (W+2)'(1) <<< FRACTION_BITS;
  localparam logic signed [W+1:0] HalfFix = (W+2)'(1) <<< (FRACTION_BITS - 1);

  logic [ModeBits-1:0] mode_flags;
  logic signed [W-1:0] clamp_low, clamp_high, repeat_low, repeat_high, range_low, range_high;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags <= '0; clamp_low <= '0; clamp_high <= OneFix[W-1:0];
      repeat_low <= '0; repeat_high <= OneFix[W-1:0];
      range_low <= '0; range_high <= OneFix[W-1:0];
    end else if (psel && penable && pwrite) begin
      case (paddr[AddrBits-1:2])
        RegMode:       mode_flags <= pwdata[ModeBits-1:0];
        RegClampLow:   clamp_low <= W'(signed'(pwdata));
        RegClampHigh:  clamp_high <= W'(signed'(pwdata));
        RegRepeatLow:  repeat_low <= W'(signed'(pwdata));
        RegRepeatHigh: repeat_high <= W'(signed'(pwdata));
        RegRangeLow:   range_low <= W'(signed'(pwdata));
        RegRangeHigh:  range_high <= W'(signed'(pwdata));
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[AddrBits-1:2])
      RegMode:       prdata = 32'(mode_flags);
      RegClampLow:   prdata = 32'(clamp_low);
      RegClampHigh:  prdata = 32'(clamp_high);
      RegRepeatLow:  prdata = 32'(repeat_low);
      RegRepeatHigh: prdata = 32'(repeat_high);
      RegRangeLow:   prdata = 32'(range_low);
      RegRangeHigh:  prdata = 32'(range_high);
      default:       prdata = '0;
    endcase
  end

  // Advance the whole pipeline when the output slot is free or being taken.
  logic advance;
  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Stage 1: absolute value with saturation.
  logic v1, sat1;
  logic signed [W-1:0] x1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= s_tvalid;
    if (advance) begin
      x1 <= s_tdata; sat1 <= 1'b0;
      if (mode_flags[ModeAbs] && s_tdata[W-1]) begin
        if (s_tdata == {1'b1, {(W-1){1'b0}}}) begin
          x1 <= WMax[W-1:0]; sat1 <= 1'b1;
        end else begin
          x1 <= -$signed(s_tdata);
        end
      end
    end
  end

  // Stage 2: clamp, low bound last. Pick numerator factors, divisor and offset.
  logic signed [W-1:0] xc;
  always_comb begin
    xc = x1;
    if (mode_flags[ModeClamp]) begin
      if (xc > clamp_high) xc = clamp_high;
      if (xc < clamp_low) xc = clamp_low;
    end
  end

  logic v2, sat2, byp2, sub2;
  op_t op2;
  logic signed [W:0] fa2, fb2;
  logic signed [W+1:0] den2, off2;
  logic signed [W-1:0] bv2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (advance) v2 <= v1;
    if (advance) begin
      sat2 <= sat1; op2 <= OP_DIVIDE; byp2 <= 1'b0; bv2 <= xc; off2 <= '0; sub2 <= 1'b0;
      fa2 <= '0; fb2 <= '0; den2 <= (W+2)'(1);
      if (range_low == range_high) begin
        op2 <= OP_ZERO; byp2 <= 1'b1;
        bv2 <= mode_flags[ModeRepeat] ? range_high : '0;
      end else if (mode_flags[ModeRepeat]) begin
        fa2 <= (W+1)'(xc) - (W+1)'(range_low);
        fb2 <= (W+1)'(repeat_high) - (W+1)'(repeat_low);
        den2 <= (W+2)'(range_high) - (W+2)'(range_low);
        off2 <= (W+2)'(repeat_low);
      end else if (mode_flags[ModeCenter]) begin
        if (xc > 0) begin
          fa2 <= (W+1)'(xc); fb2 <= (W+1)'(OneFix);
          den2 <= (W+2)'(range_high) <<< 1; off2 <= HalfFix;
        end else if (range_low == 0) begin
          op2 <= OP_ZERO; byp2 <= 1'b1; bv2 <= '0;
        end else begin
          // Subtract the saturated quotient v/(2*low) from one half.
          fa2 <= (W+1)'(xc); fb2 <= (W+1)'(OneFix);
          den2 <= (W+2)'(range_low) <<< 1; off2 <= HalfFix; sub2 <= 1'b1;
        end
      end else if (mode_flags[ModeScale]) begin
        fa2 <= (W+1)'(xc) - (W+1)'(range_low); fb2 <= (W+1)'(OneFix);
        den2 <= (range_high < 0 ? -(W+2)'(range_high) : (W+2)'(range_high)) +
                (range_low < 0 ? -(W+2)'(range_low) : (W+2)'(range_low));
      end else begin
        op2 <= OP_PASS; byp2 <= 1'b1;
      end
    end
  end

  // Stage 3: magnitudes and signs.
  logic v3, sat3, byp3, neg3, dz3, sub3;
  logic [W:0] ma3, mb3, md3;
  logic signed [W+1:0] off3;
  logic signed [W-1:0] bv3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (advance) v3 <= v2;
    if (advance) begin
      sat3 <= sat2; byp3 <= byp2 || (op2 != OP_DIVIDE); bv3 <= bv2; off3 <= off2;
      sub3 <= sub2;
      ma3 <= fa2[W] ? (W+1)'(-fa2) : (W+1)'(fa2);
      mb3 <= fb2[W] ? (W+1)'(-fb2) : (W+1)'(fb2);
      md3 <= den2[W+1] ? (W+1)'(-den2) : (W+1)'(den2);
      dz3 <= (den2 == 0);
      neg3 <= (fa2 != 0 && fb2 != 0 && (fa2[W] != fb2[W])) != (den2 != 0 && den2[W+1]);
    end
  end

  // Stage 4: product of the two numerator magnitudes.
  logic v4, sat4, byp4, neg4, dz4, sub4;
  logic [NB-1:0] num4;
  logic [W:0] md4;
  logic signed [W+1:0] off4;
  logic signed [W-1:0] bv4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (advance) v4 <= v3;
    if (advance) begin
      sat4 <= sat3; byp4 <= byp3; bv4 <= bv3; off4 <= off3; md4 <= md3;
      dz4 <= dz3; neg4 <= neg3; sub4 <= sub3;
      num4 <= NB'(ma3) * NB'(mb3);
    end
  end

  trm_divider #(.NumBits(NB), .WordBits(W)) u_div (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(v4), .in_num(num4), .in_den(md4), .in_neg(neg4), .in_den_zero(dz4),
    .in_offset(off4), .in_sub(sub4), .in_bypass(byp4), .in_bypass_value(bv4),
    .in_sat(sat4),
    .out_valid(m_tvalid), .out_value(m_tdata), .out_sat(m_tuser)
  );
endmodule
`default_nettype wire

[tb/sv/texcoord_range_mapper_tb.sv]
// Testbench for the texture coordinate range mapper: table-driven and random beats.
`default_nettype none
module texcoord_range_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trm_pkg::*;

  localparam int W = WordBits;
  localparam int F = FractionBits;
  localparam longint WMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam longint ONE = 64'sd1 <<< F;
  localparam longint HALF = 64'sd1 <<< (F - 1);
  // Pipeline depth plus margin.
  localparam int DRAIN = 2 * W + 20;
  localparam longint LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [W-1:0] s_tdata = '0;   // sample_value
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [W-1:0] m_tdata;        // mapped_value
  logic m_tuser;                // saturated

  texcoord_range_mapper DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  typedef struct packed {
    logic [W-1:0] mapped;
    logic sat;
  } coord_t;

  // Shadow copy of the register file.
  logic [ModeBits-1:0] mode_q;
  longint clo_q, chi_q, rlo_q, rhi_q, nlo_q, nhi_q;

  coord_t coord_q[$];
  bit failed = 0;
  longint cycles = 0;

  // Truncating a*b/d with saturation to the word range.
  function automatic longint mul_div_sat(longint a, longint b, longint d, ref bit sat);
    logic signed [127:0] num, q;
    begin
      num = 128'(signed'(a)) * 128'(signed'(b));
      if (d == 0) begin
        sat = 1;
        return (num < 0) ? WMIN : WMAX;
      end
      q = num / 128'(signed'(d));
      if (q > WMAX) begin sat = 1; return WMAX; end
      if (q < WMIN) begin sat = 1; return WMIN; end
      return longint'(q);
    end
  endfunction

  function automatic longint clip(longint v, ref bit sat);
    if (v > WMAX) begin sat = 1; return WMAX; end
    if (v < WMIN) begin sat = 1; return WMIN; end
    return v;
  endfunction

  function automatic coord_t map_sample(logic [W-1:0] raw);
    longint v, s;
    bit sat;
    coord_t r;
    begin
      sat = 0;
      v = longint'(signed'(raw));
      if (mode_q[ModeAbs]) v = clip(v < 0 ? -v : v, sat);
      if (mode_q[ModeClamp]) begin
        if (v > chi_q) v = chi_q;
        if (v < clo_q) v = clo_q;
      end
      if (nlo_q == nhi_q) begin
        v = mode_q[ModeRepeat] ? nhi_q : 0;
      end else if (mode_q[ModeRepeat]) begin
        v = mul_div_sat(v - nlo_q, rhi_q - rlo_q, nhi_q - nlo_q, sat);
        v = clip(v + rlo_q, sat);
      end else if (mode_q[ModeCenter]) begin
        if (v > 0) begin
          v = mul_div_sat(v, ONE, 2 * nhi_q, sat);
          v = clip(v + HALF, sat);
        end else if (nlo_q == 0) begin
          v = 0;
        end else begin
          v = mul_div_sat(v, ONE, 2 * nlo_q, sat);
          v = clip(HALF - v, sat);
        end
      end else if (mode_q[ModeScale]) begin
        s = (nhi_q < 0 ? -nhi_q : nhi_q) + (nlo_q < 0 ? -nlo_q : nlo_q);
        v = mul_div_sat(v - nlo_q, ONE, s, sat);
      end
      r.mapped = v[W-1:0];
      r.sat = sat;
      return r;
    end
  endfunction

  // Write one register over the APB port and mirror it.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrBits'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegMode:       mode_q = val[ModeBits-1:0];
      RegClampLow:   clo_q = longint'(signed'(val));
      RegClampHigh:  chi_q = longint'(signed'(val));
      RegRepeatLow:  rlo_q = longint'(signed'(val));
      RegRepeatHigh: rhi_q = longint'(signed'(val));
      RegRangeLow:   nlo_q = longint'(signed'(val));
      RegRangeHigh:  nhi_q = longint'(signed'(val));
      default: ;
    endcase
  endtask

  // Wait until every expected beat has come back, then let the pipe empty.
  task automatic drain_pipe();
    while (coord_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic int gap_len();
    int p;
    begin
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
    end
  endfunction

  // Push one beat after an optional random gap and queue its model expectation.
  task automatic send_sample(logic [W-1:0] val, bit calm);
    int g;
    g = calm ? 0 : gap_len();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= val;
    do @(posedge clk); while (!s_tready);
    coord_q.push_back(map_sample(val));
  endtask

  // Receiver: random stalls, compare every beat with the oldest expectation.
  bit calm_rx = 0;
  always @(posedge clk) begin
    coord_t want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (coord_q.size() == 0) begin
          $error("unexpected beat mapped_value=%h", m_tdata);
          failed = 1;
        end else begin
          want = coord_q.pop_front();
          if (m_tdata !== want.mapped) begin
            $error("mapped_value expected %h got %h", want.mapped, m_tdata);
            failed = 1;
          end
          if (m_tuser !== want.sat) begin
            $error("saturated expected %b got %b", want.sat, m_tuser);
            failed = 1;
          end
        end
      end
      m_tready <= calm_rx ? 1'b1 : (gap_len() == 0);
    end
  end

  // Directed rows: register setting then sample; known marks a hand-typed expected value.
  typedef struct {
    logic [31:0] mode;
    logic [31:0] lo;    // range_low
    logic [31:0] hi;    // range_high
    logic [31:0] sample;
    logic [W-1:0] want;
    bit known;
  } row_t;

  localparam int NROWS = 16;
  row_t rows[NROWS] = '{
    // after reset: pass-through
    '{0, 0, 32'h10000, 32'h80000000, 32'h80000000, 1},
    '{0, 0, 32'h10000, 32'h7fffffff, 32'h7fffffff, 1},
    // absolute of most negative saturates
    '{1, 0, 32'h10000, 32'h80000000, 32'h7fffffff, 1},
    // degenerate range: 0, or range_high in repeat mode
    '{0, 32'h5000, 32'h5000, 32'h1234, 0, 1},
    '{4, 32'h5000, 32'h5000, 32'h1234, 32'h5000, 1},
    // clamp with low above high: low wins; then repeat mode
    '{2, 0, 32'h10000, 32'h7fffffff, 0, 0},
    '{4, 0, 32'h10000, 32'h8000, 0, 0},
    '{4, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0},
    // center: positive, zero with range_low zero, negative
    '{8, 0, 32'h10000, 32'h10000, 0, 0},
    '{8, 0, 32'h10000, 32'hffff0000, 0, 1},
    '{8, 32'hfffe0000, 32'h10000, 32'hffff0000, 0, 0},
    // center with range_high zero: divide by zero
    '{8, 32'hfffe0000, 0, 32'h100, 32'h7fffffff, 1},
    '{24, 32'hfffe0000, 32'h10000, 32'h8000, 0, 0},
    // scale, then all mode bits set
    '{16, 32'hfffe0000, 32'h20000, 32'h7fffffff, 0, 0},
    '{16, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0},
    '{31, 32'h1000, 32'h2000, 32'hffffffff, 0, 0}
  };

  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
    endcase
  endfunction

  initial begin
    coord_t exp_row;
    mode_q = 0; clo_q = 0; chi_q = ONE; rlo_q = 0; rhi_q = ONE; nlo_q = 0; nhi_q = ONE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Clamp window inverted for the clamp row; repeat range spans the full word.
    for (int i = 0; i < NROWS; i++) begin
      drain_pipe();
      if (i == 5) begin
        write_reg(RegClampLow, 32'h20000);
        write_reg(RegClampHigh, 32'h10000);
      end
      if (i == 7) begin
        write_reg(RegRepeatLow, 32'h80000000);
        write_reg(RegRepeatHigh, 32'h7fffffff);
      end
      write_reg(RegMode, rows[i].mode);
      write_reg(RegRangeLow, rows[i].lo);
      write_reg(RegRangeHigh, rows[i].hi);
      exp_row = map_sample(rows[i].sample);
      if (rows[i].known && exp_row.mapped !== rows[i].want) begin
        $error("mapped_value expected %h got %h", rows[i].want, exp_row.mapped);
        failed = 1;
      end
      send_sample(rows[i].sample, 0);
      s_tvalid <= 1'b0;
    end

    // Random phases, each with fresh register settings.
    for (int ph = 0; ph < 40; ph++) begin
      drain_pipe();
      calm_rx = (ph % 7 == 3);
      write_reg(RegMode, $urandom_range(0, 31));
      write_reg(RegClampLow, rand_fix());
      write_reg(RegClampHigh, rand_fix());
      write_reg(RegRepeatLow, rand_fix());
      write_reg(RegRepeatHigh, rand_fix());
      write_reg(RegRangeLow, rand_fix());
      write_reg(RegRangeHigh, $urandom_range(0, 9) == 0 ? 32'(nlo_q) : rand_fix());
      for (int k = 0; k < 50; k++) begin
        // hold off once mid-phase until every result is back
        if (ph == 5 && k == 25) begin
          s_tvalid <= 1'b0;
          while (coord_q.size() != 0) @(posedge clk);
        end
        send_sample(rand_fix(), ph % 7 == 3);
      end
      s_tvalid <= 1'b0;
    end

    drain_pipe();
    if (!failed) begin
      $display("texcoord_range_mapper: match");
    end else begin
      $display("texcoord_range_mapper: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("texcoord_range_mapper: mismatch");
      $finish;
    end
  end
endmodule
`default_nettype wire
